FILE: rtl/core/kbhm_pkg.sv
// Package for the keep-best hash map: table sizing, hash constants,
// operation and status codes, and the item, entry and result types.
// No dependencies; every other file in rtl/core except kbhm_ram imports it.
package kbhm_pkg;

	// Table depth is a power of two: the home slot is the low bits of the hash
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Depth of the queue between the hash front end and the probe engine
	localparam int QUEUE_DEPTH = 4;

	// 64-bit finalizer constants
	localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam logic [31:0] MIX_C1_LO = MIX_C1[31:0];
	localparam logic [31:0] MIX_C1_HI = MIX_C1[63:32];
	localparam logic [31:0] MIX_C2_LO = MIX_C2[31:0];
	localparam logic [31:0] MIX_C2_HI = MIX_C2[63:32];
	localparam int          MIX_SHIFT = 33;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STATUS_NEW      = 3'd0,
		STATUS_REPLACED = 3'd1,
		STATUS_KEPT     = 3'd2,
		STATUS_HIT      = 3'd3,
		STATUS_MISS     = 3'd4,
		STATUS_FULL     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PROBE
	} back_state_t;

	// One request as it arrives on the input ports
	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [15:0] weight;
		logic [62:0] prod_high;
		logic [63:0] prod_low;
	} req_t;

	// A request with its home slot, as queued for the probe engine
	typedef struct packed {
		req_t             req;
		logic [IDX_W-1:0] home;
	} item_t;

	// One table slot
	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [15:0] weight;
		logic [62:0] prod_high;
		logic [63:0] prod_low;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] weight;
		logic [62:0] prod_high;
		logic [63:0] prod_low;
	} result_t;

endpackage

FILE: rtl/core/keep_best_hash_map.sv
// Top level of the keep-best hash map: hash front end, request queue and
// probe engine. Depends on kbhm_pkg, kbhm_front, kbhm_fifo and kbhm_back.
//
// Requests enter through a queue-style port (push/full) and results leave
// through another (empty/pop), one result per request, in order. After reset
// the table is cleared one slot per cycle until all 4096 slots are empty,
// and full stays high meanwhile. The home slot is computed in a four-stage
// pipeline, which stalls when its last stage cannot hand over to a full
// queue; up to four hashed requests wait in that queue ahead of the engine.
// The probe engine owns the single table RAM port pair and handles one
// request at a time: it issues the home-slot read as it takes a request,
// then checks slots in order until it finds its key or an empty slot or has
// visited all 4096. A finished result waits in an output register while the
// front end keeps accepting new requests.
module keep_best_hash_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [31:0] key,
	input  logic [15:0] weight_in,
	input  logic [62:0] prod_in_high,
	input  logic [63:0] prod_in_low,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [15:0] weight_out,
	output logic [62:0] prod_out_high,
	output logic [63:0] prod_out_low
);
	import kbhm_pkg::*;

	logic    clearing;
	logic    fq_push;
	item_t   fq_item;
	logic    fq_full;
	item_t   bq_item;
	logic    bq_empty;
	logic    bq_pop;
	result_t res;
	logic    res_valid;

	kbhm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.key          (key),
		.weight_in    (weight_in),
		.prod_in_high (prod_in_high),
		.prod_in_low  (prod_in_low),
		.hold         (clearing),
		.q_push       (fq_push),
		.q_item       (fq_item),
		.q_full       (fq_full)
	);

	kbhm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.item_in  (fq_item),
		.full     (fq_full),
		.pop      (bq_pop),
		.item_out (bq_item),
		.empty    (bq_empty)
	);

	kbhm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (bq_item),
		.q_empty   (bq_empty),
		.q_pop     (bq_pop),
		.clearing  (clearing),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	// Drive the result ports from the output register
	assign empty         = !res_valid;
	assign status        = res.status;
	assign weight_out    = res.weight;
	assign prod_out_high = res.prod_high;
	assign prod_out_low  = res.prod_low;

	// No request enters and no result appears while the table is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (full && empty))
		else $error("transaction moved during table clear");

	// Probe engine takes only from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bq_pop |-> !bq_empty)
		else $error("probe engine popped an empty queue");

	// Front end hands over only when the queue has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fq_push |-> !fq_full)
		else $error("front end pushed into a full queue");

	// A request is taken only when the result register will be free
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		bq_pop |-> (empty || pop))
		else $error("request taken while a result still waits");

endmodule

FILE: rtl/core/kbhm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module kbhm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/kbhm_front.sv
// Front end of the keep-best hash map: accepts requests and computes the home
// slot through a four-stage finalizer pipeline. Depends on kbhm_pkg.
module kbhm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 operation,
	input  logic [31:0]          key,
	input  logic [15:0]          weight_in,
	input  logic [62:0]          prod_in_high,
	input  logic [63:0]          prod_in_low,
	input  logic                 hold,
	output logic                 q_push,
	output kbhm_pkg::item_t      q_item,
	input  logic                 q_full
);
	import kbhm_pkg::*;

	logic        adv;
	logic        accept;
	req_t        req_in;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	req_t        req_s1, req_s2, req_s3, req_s4;
	logic [63:0] p0_s1;
	logic [31:0] p1_s1;
	logic [63:0] v2_s2;
	logic [63:0] m0_s3;
	logic [31:0] m1_s3;
	logic [31:0] a1_s3;
	logic [63:0] v3_s4;

	logic [63:0] mul_p0;
	logic [31:0] mul_p1;
	logic [63:0] mix_v1;
	logic [63:0] mix_v2;
	logic [63:0] mul_m0;
	logic [31:0] mul_m1;
	logic [31:0] mul_m2;
	logic [31:0] mix_hi;
	logic [63:0] mix_v4;

	// Advance the whole pipeline unless the last stage is blocked by the queue
	assign adv    = !valid_s4 || !q_full;
	assign full   = !adv || hold;
	assign accept = push && !full;

	assign req_in.op        = op_t'(operation);
	assign req_in.key       = key;
	assign req_in.weight    = weight_in;
	assign req_in.prod_high = prod_in_high;
	assign req_in.prod_low  = prod_in_low;

	// Stage 1: key times first constant, split into two 32-bit halves
	assign mul_p0 = 64'(key) * 64'(MIX_C1_LO);
	assign mul_p1 = key * MIX_C1_HI;

	// Stage 2: combine partial products, first xor-shift after the multiply
	assign mix_v1 = p0_s1 + {p1_s1, 32'd0};
	assign mix_v2 = mix_v1 ^ (mix_v1 >> MIX_SHIFT);

	// Stage 3: low half times second constant
	assign mul_m0 = 64'(v2_s2[31:0]) * 64'(MIX_C2_LO);
	assign mul_m1 = v2_s2[31:0] * MIX_C2_HI;

	// Stage 4: high half cross product and upper word sum
	assign mul_m2 = a1_s3 * MIX_C2_LO;
	assign mix_hi = m0_s3[63:32] + m1_s3 + mul_m2;

	// Final xor-shift and truncation to the slot index
	assign mix_v4      = v3_s4 ^ (v3_s4 >> MIX_SHIFT);
	assign q_push      = valid_s4 && !q_full;
	assign q_item.req  = req_s4;
	assign q_item.home = mix_v4[IDX_W-1:0];

	// Advance valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Advance payload and hash terms
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req_in;
			p0_s1  <= mul_p0;
			p1_s1  <= mul_p1;
			req_s2 <= req_s1;
			v2_s2  <= mix_v2;
			req_s3 <= req_s2;
			m0_s3  <= mul_m0;
			m1_s3  <= mul_m1;
			a1_s3  <= v2_s2[63:32];
			req_s4 <= req_s3;
			v3_s4  <= {mix_hi, m0_s3[31:0]};
		end
	end

endmodule

FILE: rtl/core/kbhm_fifo.sv
// Short queue of hashed requests between the front end and the probe engine.
// Depends on kbhm_pkg for the item type and depth.
module kbhm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kbhm_pkg::item_t item_in,
	output logic            full,
	input  logic            pop,
	output kbhm_pkg::item_t item_out,
	output logic            empty
);
	import kbhm_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign item_out = entry_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

FILE: rtl/core/kbhm_back.sv
// Probe engine of the keep-best hash map: clears the table after reset, then
// walks slots by linear probing and holds the result register.
// Depends on kbhm_pkg and kbhm_ram.
module kbhm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  kbhm_pkg::item_t   q_item,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              clearing,
	output kbhm_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_pop
);
	import kbhm_pkg::*;

	back_state_t      state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] probe_q;
	req_t             cur_q;
	result_t          res_q;
	logic             res_valid_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t           rd_entry;

	logic             key_hit;
	logic             better;
	logic             last_probe;
	logic             clr_last;
	logic             res_load;
	result_t          res_next;
	entry_t           cand_entry;

	kbhm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry   = entry_t'(ram_rdata);
	assign key_hit    = rd_entry.valid && (rd_entry.key == cur_q.key);
	assign better     = (cur_q.weight < rd_entry.weight) ||
		((cur_q.weight == rd_entry.weight) &&
		({cur_q.prod_high, cur_q.prod_low} < {rd_entry.prod_high, rd_entry.prod_low}));
	assign last_probe = probe_q == IDX_W'(TABLE_DEPTH - 1);
	assign clr_last   = clr_q == IDX_W'(TABLE_DEPTH - 1);

	assign cand_entry.valid     = 1'b1;
	assign cand_entry.key       = cur_q.key;
	assign cand_entry.weight    = cur_q.weight;
	assign cand_entry.prod_high = cur_q.prod_high;
	assign cand_entry.prod_low  = cur_q.prod_low;

	assign clearing  = state_q == BK_CLEAR;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_pop) begin
					state_d = BK_PROBE;
				end
			end
			BK_PROBE: begin
				if (res_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Table access, queue pop and result decode
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = cand_entry;
		ram_raddr = q_item.home;
		q_pop     = 1'b0;
		res_load  = 1'b0;
		res_next  = '0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			BK_IDLE: begin
				q_pop = !q_empty && (!res_valid_q || res_pop);
			end
			BK_PROBE: begin
				ram_raddr = slot_q + 1'b1;
				if (!rd_entry.valid) begin
					// Empty slot ends the chain
					res_load = 1'b1;
					if (cur_q.op == OP_INSERT) begin
						ram_we          = 1'b1;
						res_next.status = STATUS_NEW;
					end else begin
						res_next.status = STATUS_MISS;
					end
				end else if (key_hit) begin
					res_load = 1'b1;
					if (cur_q.op == OP_INSERT) begin
						if (better) begin
							ram_we          = 1'b1;
							res_next.status = STATUS_REPLACED;
						end else begin
							res_next.status = STATUS_KEPT;
						end
					end else begin
						res_next.status    = STATUS_HIT;
						res_next.weight    = rd_entry.weight;
						res_next.prod_high = rd_entry.prod_high;
						res_next.prod_low  = rd_entry.prod_low;
					end
				end else if (last_probe) begin
					// Every slot visited without a match or a hole
					res_load        = 1'b1;
					res_next.status = (cur_q.op == OP_INSERT) ? STATUS_FULL : STATUS_MISS;
				end
			end
			default: ;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Load the request, step the probe, capture the result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q   <= q_item.req;
			slot_q  <= q_item.home;
			probe_q <= '0;
		end else if (state_q == BK_PROBE && !res_load) begin
			slot_q  <= slot_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
		if (res_load) begin
			res_q <= res_next;
		end
	end

endmodule
